[design/lcr_pkg.sv]
// Shared types and constants for the load cell reader.
// No dependencies; every other design file uses this package.
package lcr_pkg;

  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_TARE_SAMPLES = 20;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 8'd3;

  localparam logic [15:0]        RST_HALF_PERIOD = 16'd100;
  localparam logic [31:0]        RST_TIMEOUT     = 32'd50000000;
  localparam logic [1:0]         RST_GAIN_PULSES = 2'd3;
  localparam logic signed [31:0] RST_SCALE       = 32'sd65536;

  typedef struct packed {
    logic [15:0]        half_period_ticks;
    logic [31:0]        timeout_ticks;
    logic [1:0]         gain_pulses;
    logic signed [31:0] scale_factor;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

endpackage

[design/lcr_if.sv]
// Channel interfaces for the load cell reader: tick input, result output
// and configuration write. Depends on lcr_pkg.
interface lcr_in_if;
  logic valid;
  logic ready;
  logic dout_level;
  logic tare_button;

  modport source (output valid, dout_level, tare_button, input ready);
  modport sink   (input valid, dout_level, tare_button, output ready);
endinterface

interface lcr_out_if #(
  parameter int SAMPLE_BITS = lcr_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          sclk;
  logic                          sample_valid;
  logic signed [SAMPLE_BITS-1:0] raw_sample;
  logic signed [SAMPLE_BITS+32:0] weight;
  logic                          timed_out;
  logic                          taring;
  logic                          tare_done;
  logic signed [SAMPLE_BITS-1:0] offset_out;

  modport source (output valid, sclk, sample_valid, raw_sample, weight, timed_out,
                  taring, tare_done, offset_out, input ready);
  modport sink   (input valid, sclk, sample_valid, raw_sample, weight, timed_out,
                  taring, tare_done, offset_out, output ready);
endinterface

interface lcr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lcr_pkg::CFG_IDX_W-1:0]   index;
  logic [lcr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/lcr_cfg_regs.sv]
// Configuration register file for the load cell reader.
// Depends on lcr_pkg (cfg_t, register map, reset values).
module lcr_cfg_regs import lcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        REG_HALF_PERIOD: cfg_nxt.half_period_ticks = wr_data[15:0];
        REG_TIMEOUT:     cfg_nxt.timeout_ticks     = wr_data[31:0];
        REG_GAIN_PULSES: cfg_nxt.gain_pulses       = wr_data[1:0];
        REG_SCALE:       cfg_nxt.scale_factor      = $signed(wr_data[31:0]);
        default:         cfg_nxt = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= RST_HALF_PERIOD;
      cfg_r.timeout_ticks     <= RST_TIMEOUT;
      cfg_r.gain_pulses       <= RST_GAIN_PULSES;
      cfg_r.scale_factor      <= RST_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/lcr_seq.sv]
// Tick sequencer: input register, serial read state machine and tare
// accumulation. Depends on lcr_pkg (cfg_t, phase_t).
module lcr_seq import lcr_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          dout_level,
  input  logic                          tare_button,
  input  cfg_t                          cfg,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_sclk,
  output logic                          m_sample_valid,
  output logic signed [SAMPLE_BITS-1:0] m_raw,
  output logic                          m_timed_out,
  output logic                          m_taring,
  output logic                          m_tare_done,
  output logic signed [SAMPLE_BITS+4:0] m_tare_sum
);

  localparam int SUM_W = SAMPLE_BITS + 5;
  localparam int BC_W  = $clog2(SAMPLE_BITS + 4);
  localparam int TC_W  = $clog2(TARE_SAMPLES + 1);

  // stage 1: tick register
  logic v1_r, dout1_r, btn1_r;
  // stage 2: result of the state update
  logic v2_r;
  logic en1, en2, go;

  // read state
  phase_t                   phase_r, phase_nxt;
  logic                     pend_r, pend_nxt;
  logic                     active_r, active_nxt;
  logic                     held_r, held_nxt;
  logic [BC_W-1:0]          bc_r, bc_nxt;
  logic [SAMPLE_BITS-1:0]   shift_r, shift_nxt;
  logic [31:0]              timer_r, timer_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TC_W-1:0]          cnt_r, cnt_nxt;
  logic                     lastto_r, lastto_nxt;

  // per tick results
  logic                          sclk_c, sv_c, done_c, fin, fin_to;
  logic signed [SAMPLE_BITS-1:0] raw_c, r_c;
  logic signed [SUM_W-1:0]       sum_out_c, sum_add;
  logic [15:0]                   hp;
  logic [31:0]                   t_inc;
  logic [BC_W-1:0]               bc_lim;
  logic [TC_W-1:0]               cnt_inc;

  assign en2      = !v2_r || m_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign go       = v1_r && en2;
  assign m_valid  = v2_r;

  assign hp     = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
  assign t_inc  = timer_r + 32'd1;
  assign bc_lim = BC_W'(SAMPLE_BITS) + BC_W'(cfg.gain_pulses);

  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r | (btn1_r & ~held_r);
    held_nxt   = btn1_r;
    active_nxt = active_r;
    bc_nxt     = bc_r;
    shift_nxt  = shift_r;
    timer_nxt  = timer_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    lastto_nxt = lastto_r;
    sclk_c     = 1'b0;
    sv_c       = 1'b0;
    done_c     = 1'b0;
    fin        = 1'b0;
    fin_to     = 1'b0;
    raw_c      = '0;
    r_c        = '0;
    sum_add    = '0;
    cnt_inc    = '0;
    sum_out_c  = sum_r;

    case (phase_r)
      PH_WAIT: begin
        if (pend_nxt && !active_r) begin
          pend_nxt   = 1'b0;
          active_nxt = 1'b1;
          cnt_nxt    = '0;
          sum_nxt    = '0;
        end
        if (!dout1_r) begin
          phase_nxt = PH_HIGH;
          timer_nxt = '0;
          bc_nxt    = '0;
          shift_nxt = '0;
        end else if (timer_r >= cfg.timeout_ticks) begin
          timer_nxt = '0;
          fin       = 1'b1;
          fin_to    = 1'b1;
        end else begin
          timer_nxt = t_inc;
        end
      end
      PH_HIGH: begin
        sclk_c = 1'b1;
        if (t_inc >= {16'd0, hp}) begin
          if (bc_r < BC_W'(SAMPLE_BITS))
            shift_nxt = {shift_r[SAMPLE_BITS-2:0], dout1_r};
          bc_nxt    = bc_r + BC_W'(1);
          phase_nxt = PH_LOW;
          timer_nxt = '0;
        end else begin
          timer_nxt = t_inc;
        end
      end
      PH_LOW: begin
        if (t_inc >= {16'd0, hp}) begin
          timer_nxt = '0;
          if (bc_r >= bc_lim) begin
            phase_nxt = PH_WAIT;
            fin       = 1'b1;
          end else begin
            phase_nxt = PH_HIGH;
          end
        end else begin
          timer_nxt = t_inc;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase

    if (fin) begin
      r_c        = fin_to ? '0 : $signed(shift_r);
      lastto_nxt = fin_to;
      if (active_nxt) begin
        sum_add = sum_nxt + SUM_W'(r_c);
        cnt_inc = cnt_nxt + TC_W'(1);
        if (cnt_inc >= TC_W'(TARE_SAMPLES)) begin
          done_c     = 1'b1;
          active_nxt = 1'b0;
          cnt_nxt    = '0;
          sum_nxt    = '0;
          sum_out_c  = sum_add;
        end else begin
          cnt_nxt = cnt_inc;
          sum_nxt = sum_add;
        end
      end else begin
        sv_c  = 1'b1;
        raw_c = r_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      phase_r  <= PH_WAIT;
      pend_r   <= 1'b1;
      active_r <= 1'b0;
      held_r   <= 1'b0;
      bc_r     <= '0;
      shift_r  <= '0;
      timer_r  <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      lastto_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (go) begin
        phase_r  <= phase_nxt;
        pend_r   <= pend_nxt;
        active_r <= active_nxt;
        held_r   <= held_nxt;
        bc_r     <= bc_nxt;
        shift_r  <= shift_nxt;
        timer_r  <= timer_nxt;
        sum_r    <= sum_nxt;
        cnt_r    <= cnt_nxt;
        lastto_r <= lastto_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      dout1_r <= dout_level;
      btn1_r  <= tare_button;
    end
    if (go) begin
      m_sclk         <= sclk_c;
      m_sample_valid <= sv_c;
      m_raw          <= raw_c;
      m_timed_out    <= lastto_nxt;
      m_taring       <= active_nxt;
      m_tare_done    <= done_c;
      m_tare_sum     <= sum_out_c;
    end
  end

endmodule

[design/lcr_scale.sv]
// Offset and weight stages: tare average by reciprocal multiply, offset
// subtraction, then Q16.16 scaling into the result register. Depends on lcr_pkg.
module lcr_scale import lcr_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           m_valid,
  output logic                           m_ready,
  input  logic                           m_sclk,
  input  logic                           m_sample_valid,
  input  logic signed [SAMPLE_BITS-1:0]  m_raw,
  input  logic                           m_timed_out,
  input  logic                           m_taring,
  input  logic                           m_tare_done,
  input  logic signed [SAMPLE_BITS+4:0]  m_tare_sum,
  input  logic signed [31:0]             scale_factor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_sclk,
  output logic                           out_sample_valid,
  output logic signed [SAMPLE_BITS-1:0]  out_raw_sample,
  output logic signed [SAMPLE_BITS+32:0] out_weight,
  output logic                           out_timed_out,
  output logic                           out_taring,
  output logic                           out_tare_done,
  output logic signed [SAMPLE_BITS-1:0]  out_offset
);

  localparam int SUM_W = SAMPLE_BITS + 5;
  localparam int MAG_W = SUM_W - 1;        // |sum| < 2^MAG_W
  localparam int K     = MAG_W + 5;        // error below 2^(K-MAG_W) >= 32 > TARE_SAMPLES
  localparam longint unsigned RECIP = ((64'd1 << K) + TARE_SAMPLES - 1) / TARE_SAMPLES;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int P_W   = MAG_W + RW;
  localparam int W_W   = SAMPLE_BITS + 33;

  logic v3_r, v4_r, en3, en4, go3;

  logic                          neg;
  logic [SUM_W-1:0]              sum_abs;
  logic [P_W-1:0]                prod;
  logic [SAMPLE_BITS-1:0]        q_mag;
  logic signed [SAMPLE_BITS-1:0] quot;
  logic signed [SAMPLE_BITS:0]   diff_c;
  logic signed [W_W-1:0]         weight_c;

  logic signed [SAMPLE_BITS-1:0] zo_r;

  logic                          sclk3_r, sv3_r, to3_r, taring3_r, done3_r;
  logic signed [SAMPLE_BITS-1:0] raw3_r, off3_r;
  logic signed [SAMPLE_BITS:0]   diff3_r;

  assign en4     = !v4_r || out_ready;
  assign en3     = !v3_r || en4;
  assign m_ready = en3;
  assign go3     = m_valid && en3;
  assign out_valid = v4_r;

  // divide by TARE_SAMPLES, truncating toward zero
  assign neg     = m_tare_sum[SUM_W-1];
  assign sum_abs = neg ? (~m_tare_sum + SUM_W'(1)) : m_tare_sum;
  assign prod    = P_W'(sum_abs[MAG_W-1:0]) * P_W'(RECIP);
  assign q_mag   = prod[K +: SAMPLE_BITS];
  assign quot    = neg ? $signed(~q_mag + SAMPLE_BITS'(1)) : $signed(q_mag);

  assign diff_c = m_sample_valid ?
                  ((SAMPLE_BITS+1)'(m_raw) - (SAMPLE_BITS+1)'(zo_r)) : '0;

  assign weight_c = W_W'(diff3_r) * W_W'(scale_factor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      zo_r <= '0;
    end else begin
      if (en3) v3_r <= m_valid;
      if (en4) v4_r <= v3_r;
      if (go3 && m_tare_done) zo_r <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      sclk3_r   <= m_sclk;
      sv3_r     <= m_sample_valid;
      raw3_r    <= m_raw;
      to3_r     <= m_timed_out;
      taring3_r <= m_taring;
      done3_r   <= m_tare_done;
      off3_r    <= m_tare_done ? quot : zo_r;
      diff3_r   <= diff_c;
    end
    if (v3_r && en4) begin
      out_sclk         <= sclk3_r;
      out_sample_valid <= sv3_r;
      out_raw_sample   <= raw3_r;
      out_weight       <= weight_c;
      out_timed_out    <= to3_r;
      out_taring       <= taring3_r;
      out_tare_done    <= done3_r;
      out_offset       <= off3_r;
    end
  end

endmodule

[design/load_cell_adc_reader_with_tare.sv]
// Top level of the load cell reader with tare.
// Depends on lcr_pkg, lcr_if, lcr_cfg_regs, lcr_seq and lcr_scale.
//
// Usage:
//   in_ch  : one item per timing tick, carrying the sampled data/ready pin
//            (dout_level) and the tare button level.
//   out_ch : exactly one result item per tick: the serial clock level for
//            that tick, plus sample_valid/raw_sample/weight when a read ends
//            outside taring, timeout flag, taring status, tare_done pulse
//            and the stored offset.
//   cfg_ch : register writes (0 half period, 1 timeout, 2 gain pulses,
//            3 Q16.16 scale); always ready, write only while idle.
// From tick accept to result an item passes four registered stages: tick
//   register, read state update, offset stage (tare average by reciprocal
//   multiply), weight multiply into the result register.
// Throughput is one tick per cycle while out_ch is ready; the state machine's
//   loop holds no extra register, so every stage can take a new item each cycle.
// Reset: config returns to defaults, the pipeline empties and a tare is
//   pending, so the first TARE_SAMPLES reads are averaged into the offset.
// Receiver stall: results hold in the output register; upstream stages keep
//   filling, and in_ch.ready drops only once all four stages are full.
module load_cell_adc_reader_with_tare import lcr_pkg::*; #(
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  lcr_in_if.sink      in_ch,
  lcr_out_if.source   out_ch,
  lcr_cfg_if.sink     cfg_ch
);

  cfg_t cfg;

  // sequencer -> offset/weight stages
  logic                          m_valid, m_ready;
  logic                          m_sclk, m_sample_valid, m_timed_out;
  logic                          m_taring, m_tare_done;
  logic signed [SAMPLE_BITS-1:0] m_raw;
  logic signed [SAMPLE_BITS+4:0] m_tare_sum;

  lcr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lcr_seq #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TARE_SAMPLES (TARE_SAMPLES)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .dout_level     (in_ch.dout_level),
    .tare_button    (in_ch.tare_button),
    .cfg            (cfg),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sclk         (m_sclk),
    .m_sample_valid (m_sample_valid),
    .m_raw          (m_raw),
    .m_timed_out    (m_timed_out),
    .m_taring       (m_taring),
    .m_tare_done    (m_tare_done),
    .m_tare_sum     (m_tare_sum)
  );

  // scale factor is read straight from config; the user must change it only while idle (not enforced here)
  lcr_scale #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TARE_SAMPLES (TARE_SAMPLES)
  ) u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_sclk           (m_sclk),
    .m_sample_valid   (m_sample_valid),
    .m_raw            (m_raw),
    .m_timed_out      (m_timed_out),
    .m_taring         (m_taring),
    .m_tare_done      (m_tare_done),
    .m_tare_sum       (m_tare_sum),
    .scale_factor     (cfg.scale_factor),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_sclk         (out_ch.sclk),
    .out_sample_valid (out_ch.sample_valid),
    .out_raw_sample   (out_ch.raw_sample),
    .out_weight       (out_ch.weight),
    .out_timed_out    (out_ch.timed_out),
    .out_taring       (out_ch.taring),
    .out_tare_done    (out_ch.tare_done),
    .out_offset       (out_ch.offset_out)
  );

endmodule

[design/lcr_checker.sv]
// Port-level checks for the load cell reader, bound to the top level.
// Depends on lcr_pkg and load_cell_adc_reader_with_tare.
module lcr_checker import lcr_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           sample_valid,
  input logic signed [SAMPLE_BITS-1:0]  raw_sample,
  input logic signed [SAMPLE_BITS+32:0] weight,
  input logic                           taring,
  input logic                           tare_done
);

  // a stalled result stays presented
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // non-sample ticks carry zero raw and weight
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sample_valid |-> raw_sample == '0 && weight == '0)
    else $error("raw/weight nonzero without a sample");

  // reads during taring never show up as samples
  a_no_sample_taring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sample_valid |-> !taring && !tare_done)
    else $error("sample presented while taring");

  // storing the offset ends the averaging
  a_done_ends_tare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tare_done |-> !taring)
    else $error("tare_done with taring still set");

endmodule

bind load_cell_adc_reader_with_tare lcr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lcr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .sample_valid (out_ch.sample_valid),
  .raw_sample   (out_ch.raw_sample),
  .weight       (out_ch.weight),
  .taring       (out_ch.taring),
  .tare_done    (out_ch.tare_done)
);
